@@ hdl/hrc_pkg.sv @@
// ============================================================================
// hrc_pkg
// shared types, constants and letter tables of the hangul romanization composer
// ============================================================================
`default_nettype none

package hrc_pkg;

    localparam int MAX_CHARS = 64;
    localparam int ADDR_W    = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int LIMIT_W   = 7;
    localparam int WIN       = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 7'd64;

    localparam logic [15:0] SYL_BASE     = 16'hAC00;
    localparam logic [15:0] INIT_STRIDE  = 16'd588;
    localparam logic [15:0] VOWEL_STRIDE = 16'd28;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [5:0]  UTF8_MASK    = 6'h3F;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } hrc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } hrc_out_t;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
        logic [1:0] len;
    } match_t;

    typedef struct packed {
        logic       load;
        logic       add;
        logic       has_vowel;
        logic [4:0] ini;
        logic [4:0] vow;
    } calc_ctl_t;

    function automatic match_t hit(input logic [4:0] idx, input logic [1:0] len);
        match_t m;
        m.found = 1'b1;
        m.idx   = idx;
        m.len   = len;
        return m;
    endfunction

    function automatic logic [15:0] init_jamo(input logic [4:0] idx);
        logic [15:0] j;
        unique case (idx)
            5'd0:    j = 16'h3131;
            5'd1:    j = 16'h3132;
            5'd2:    j = 16'h3134;
            5'd3:    j = 16'h3137;
            5'd4:    j = 16'h3138;
            5'd5:    j = 16'h3139;
            5'd6:    j = 16'h3141;
            5'd7:    j = 16'h3142;
            5'd8:    j = 16'h3143;
            5'd9:    j = 16'h3145;
            5'd10:   j = 16'h3146;
            5'd11:   j = 16'h3147;
            5'd12:   j = 16'h3148;
            5'd13:   j = 16'h3149;
            5'd14:   j = 16'h314A;
            5'd15:   j = 16'h314B;
            5'd16:   j = 16'h314C;
            5'd17:   j = 16'h314D;
            5'd18:   j = 16'h314E;
            default: j = 16'h3131;
        endcase
        return j;
    endfunction

    // longest initial consonant at the head of the window
    function automatic match_t init_match(
        input logic [7:0] c0,
        input logic [7:0] c1,
        input logic       v0,
        input logic       v1
    );
        match_t m;
        m = '0;
        if (v0 && v1)
        begin
            unique case ({c0, c1})
                "gg":    m = hit(5'd1, 2'd2);
                "dd":    m = hit(5'd4, 2'd2);
                "bb":    m = hit(5'd8, 2'd2);
                "ss":    m = hit(5'd10, 2'd2);
                "jj":    m = hit(5'd13, 2'd2);
                "ch":    m = hit(5'd14, 2'd2);
                default: m = '0;
            endcase
        end
        if (!m.found && v0)
        begin
            unique case (c0)
                "g":     m = hit(5'd0, 2'd1);
                "n":     m = hit(5'd2, 2'd1);
                "d":     m = hit(5'd3, 2'd1);
                "r":     m = hit(5'd5, 2'd1);
                "m":     m = hit(5'd6, 2'd1);
                "b":     m = hit(5'd7, 2'd1);
                "s":     m = hit(5'd9, 2'd1);
                "o":     m = hit(5'd11, 2'd1);
                "j":     m = hit(5'd12, 2'd1);
                "k":     m = hit(5'd15, 2'd1);
                "t":     m = hit(5'd16, 2'd1);
                "p":     m = hit(5'd17, 2'd1);
                "h":     m = hit(5'd18, 2'd1);
                default: m = '0;
            endcase
        end
        return m;
    endfunction

    // longest vowel at the head of the given three letters
    function automatic match_t vowel_match(
        input logic [7:0] c0,
        input logic [7:0] c1,
        input logic [7:0] c2,
        input logic       v0,
        input logic       v1,
        input logic       v2
    );
        match_t m;
        m = '0;
        if (v0 && v1 && v2)
        begin
            unique case ({c0, c1, c2})
                "yae":   m = hit(5'd3, 2'd3);
                "yeo":   m = hit(5'd6, 2'd3);
                "wae":   m = hit(5'd10, 2'd3);
                default: m = '0;
            endcase
        end
        if (!m.found && v0 && v1)
        begin
            unique case ({c0, c1})
                "ae":    m = hit(5'd1, 2'd2);
                "ya":    m = hit(5'd2, 2'd2);
                "eo":    m = hit(5'd4, 2'd2);
                "ye":    m = hit(5'd7, 2'd2);
                "wa":    m = hit(5'd9, 2'd2);
                "oe":    m = hit(5'd11, 2'd2);
                "yo":    m = hit(5'd12, 2'd2);
                "wo":    m = hit(5'd14, 2'd2);
                "we":    m = hit(5'd15, 2'd2);
                "wi":    m = hit(5'd16, 2'd2);
                "yu":    m = hit(5'd17, 2'd2);
                "eu":    m = hit(5'd18, 2'd2);
                "ui":    m = hit(5'd19, 2'd2);
                default: m = '0;
            endcase
        end
        if (!m.found && v0)
        begin
            unique case (c0)
                "a":     m = hit(5'd0, 2'd1);
                "e":     m = hit(5'd5, 2'd1);
                "o":     m = hit(5'd8, 2'd1);
                "u":     m = hit(5'd13, 2'd1);
                "i":     m = hit(5'd20, 2'd1);
                default: m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/hrc_buffer.sv @@
// ============================================================================
// hrc_buffer
// character store, one write and one registered read per cycle
// ============================================================================
`default_nettype none

module hrc_buffer
    import hrc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [MAX_CHARS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/hrc_calc.sv @@
// ============================================================================
// hrc_calc
// code point accumulator around one shared 16-bit adder
// ============================================================================
`default_nettype none

module hrc_calc
    import hrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire calc_ctl_t   ctl,
    output logic      [15:0] cp
);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic [15:0] sum;

    always_comb
    begin
        op_a = acc_reg;
        op_b = '0;
        if (ctl.load)
        begin
            op_a = ctl.has_vowel ? SYL_BASE : init_jamo(ctl.ini);
            op_b = ctl.has_vowel ? 16'({11'd0, ctl.ini} * INIT_STRIDE) : '0;
        end
        else if (ctl.add)
        begin
            op_b = ctl.has_vowel ? 16'({11'd0, ctl.vow} * VOWEL_STRIDE) : '0;
        end
    end

    assign sum = op_a + op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load || ctl.add)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign cp = acc_reg;

endmodule

`default_nettype wire

@@ hdl/hangul_romanization_composer_top.sv @@
// ============================================================================
// hangul_romanization_composer_top
// romanized korean to utf-8 composer with a load phase and a scan sequencer
// ============================================================================
// usage
//   request: start with req (in_char, in_last) is taken when busy is low,
//   one byte per cycle while loading. bytes past the store depth are dropped.
//   a request with in_last set starts the scan; busy stays high until done.
//   results: one byte per strobe cycle on result; out_last marks the final
//   byte, an empty run gives one strobe with out_valid low and out_last high.
//   cfg_we/cfg_data write out_limit; the user must write it only while the
//   block is idle, as the block itself has no check for it.
//   the scan walks positions through a five-letter window read from the
//   store one letter a cycle, then matches; an initial takes a load and
//   an add on the shared adder, then three bytes of output if its unit
//   fits (else the unit is dropped); a copied byte takes fetch and match
//   only. a finish state closes the run. a byte is held until the next
//   one is known and shows in the cycle after that; the last one shows
//   in the cycle after the close, when busy is already low and the next
//   string can load.
// reset clears the sequencer, counters and out_limit (to 16); the store is
// not cleared. the receiver cannot stall: each strobe lasts one cycle.
// ============================================================================
`default_nettype none

module hangul_romanization_composer_top
    import hrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire hrc_in_t            req,
    output logic                    strobe,
    output hrc_out_t                result,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_MATCH  = 3'd2;
    localparam logic [2:0] S_CALC0  = 3'd3;
    localparam logic [2:0] S_CALC1  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]         state_reg,     state_next;
    logic [LIMIT_W-1:0] limit_cfg_reg, limit_cfg_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT_W-1:0]   pos_reg,       pos_next;
    logic [LIMIT_W-1:0] n_reg,         n_next;
    logic [2:0]         k_reg,         k_next;
    logic [7:0]         win_reg [WIN];
    logic [7:0]         win_next [WIN];
    logic [4:0]         ini_reg,       ini_next;
    logic [4:0]         vow_reg,       vow_next;
    logic               hasv_reg,      hasv_next;
    logic [2:0]         adv_reg,       adv_next;
    logic [1:0]         e_reg,         e_next;
    logic               pend_v_reg,    pend_v_next;
    logic [7:0]         pend_b_reg,    pend_b_next;
    logic               strobe_reg,    strobe_next;
    hrc_out_t           result_reg,    result_next;

    logic               accept;
    logic               buf_we;
    logic [ADDR_W-1:0]  raddr;
    logic [7:0]         rdata;
    logic [CNT_W:0]     fetch_sum;
    logic [WIN-1:0]     win_v;
    logic [LIMIT_W-1:0] limit;
    match_t             im;
    match_t             vm;
    calc_ctl_t          calc_ctl;
    logic [15:0]        cp;
    logic               push_en;
    logic [7:0]         push_byte;
    logic [CNT_W:0]     step_sum;
    logic [CNT_W:0]     copy_sum;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign buf_we = accept && (count_reg < CNT_W'(MAX_CHARS));

    assign fetch_sum = {1'b0, pos_reg} + (CNT_W + 1)'(k_reg);
    assign raddr     = fetch_sum[ADDR_W-1:0];

    hrc_buffer u_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (req.in_char),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            win_v[i] = ({1'b0, pos_reg} + (CNT_W + 1)'(i)) < {1'b0, count_reg};
        end
    end

    always_comb
    begin
        priority if (limit_cfg_reg < LIMIT_MIN)
        begin
            limit = LIMIT_MIN;
        end
        else if (limit_cfg_reg > LIMIT_CAP)
        begin
            limit = LIMIT_CAP;
        end
        else
        begin
            limit = limit_cfg_reg;
        end
    end

    always_comb
    begin
        im = init_match(win_reg[0], win_reg[1], win_v[0], win_v[1]);
        if (im.len == 2'd2)
        begin
            vm = vowel_match(win_reg[2], win_reg[3], win_reg[4],
                             win_v[2], win_v[3], win_v[4]);
        end
        else
        begin
            vm = vowel_match(win_reg[1], win_reg[2], win_reg[3],
                             win_v[1], win_v[2], win_v[3]);
        end
    end

    assign calc_ctl.load      = (state_reg == S_CALC0);
    assign calc_ctl.add       = (state_reg == S_CALC1);
    assign calc_ctl.has_vowel = hasv_reg;
    assign calc_ctl.ini       = ini_reg;
    assign calc_ctl.vow       = vow_reg;

    hrc_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (calc_ctl),
        .cp    (cp)
    );

    assign step_sum = {1'b0, pos_reg} + (CNT_W + 1)'(adv_reg);
    assign copy_sum = {1'b0, pos_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        limit_cfg_next = limit_cfg_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        win_next       = win_reg;
        ini_next       = ini_reg;
        vow_next       = vow_reg;
        hasv_next      = hasv_reg;
        adv_next       = adv_reg;
        e_next         = e_reg;
        pend_v_next    = pend_v_reg;
        pend_b_next    = pend_b_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        push_en        = 1'b0;
        push_byte      = win_reg[0];

        if (cfg_we)
        begin
            limit_cfg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (buf_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (req.in_last)
                    begin
                        pos_next    = '0;
                        n_next      = '0;
                        k_next      = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (k_reg != 3'd0)
                begin
                    win_next[k_reg - 3'd1] = rdata;
                end
                if (k_reg == 3'(WIN))
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_MATCH:
            begin
                k_next = '0;
                if (!im.found)
                begin
                    if ((n_reg + LIMIT_W'(1)) >= limit)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        push_en   = 1'b1;
                        push_byte = win_reg[0];
                        n_next    = n_reg + LIMIT_W'(1);
                        pos_next  = copy_sum[CNT_W-1:0];
                        state_next = (copy_sum >= {1'b0, count_reg}) ? S_FINISH : S_FETCH;
                    end
                end
                else
                begin
                    ini_next   = im.idx;
                    vow_next   = vm.idx;
                    hasv_next  = vm.found;
                    adv_next   = {1'b0, im.len} + (vm.found ? {1'b0, vm.len} : 3'd0);
                    state_next = S_CALC0;
                end
            end
            S_CALC0:
            begin
                state_next = S_CALC1;
            end
            S_CALC1:
            begin
                e_next = '0;
                if ((n_reg + LIMIT_W'(3)) < limit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    pos_next   = step_sum[CNT_W-1:0];
                    state_next = (step_sum >= {1'b0, count_reg}) ? S_FINISH : S_FETCH;
                end
            end
            S_EMIT:
            begin
                push_en = 1'b1;
                unique case (e_reg)
                    2'd0:    push_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
                    2'd1:    push_byte = UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK};
                    default: push_byte = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK};
                endcase
                if (e_reg == 2'd2)
                begin
                    n_next     = n_reg + LIMIT_W'(3);
                    pos_next   = step_sum[CNT_W-1:0];
                    state_next = (step_sum >= {1'b0, count_reg}) ? S_FINISH : S_FETCH;
                end
                else
                begin
                    e_next = e_reg + 2'd1;
                end
            end
            S_FINISH:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte  = pend_v_reg ? pend_b_reg : 8'd0;
                result_next.out_valid = pend_v_reg;
                result_next.out_last  = 1'b1;
                pend_v_next          = 1'b0;
                count_next           = '0;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold one byte back so the final one can carry out_last
        if (push_en)
        begin
            if (pend_v_reg)
            begin
                strobe_next           = 1'b1;
                result_next.out_byte  = pend_b_reg;
                result_next.out_valid = 1'b1;
                result_next.out_last  = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_b_next = push_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_cfg_reg <= LIMIT_RESET;
            count_reg     <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            e_reg         <= '0;
            pend_v_reg    <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_cfg_reg <= limit_cfg_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            e_reg         <= e_next;
            pend_v_reg    <= pend_v_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        ini_reg    <= ini_next;
        vow_reg    <= vow_next;
        hasv_reg   <= hasv_next;
        adv_reg    <= adv_next;
        pend_b_reg <= pend_b_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ tb/tb_hangul_romanization_composer_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_hangul_romanization_composer_top
// checks the romanized korean to utf-8 composer against its own predictor:
// strings are loaded one byte per request in random bursts, the predictor
// composes the expected utf-8 bytes when the last byte is taken, and every
// strobed result is compared in order; out_limit is changed between strings
// ============================================================================

module tb_hangul_romanization_composer_top;
    import hrc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_BYTES = 360;

    class hangul_scoreboard;
        logic [7:0]         text_buf[MAX_CHARS];
        int unsigned        text_len;
        logic [LIMIT_W-1:0] byte_cap;
        hrc_out_t           pending[$];
        int unsigned        fails;
        string              onset_txt[19];
        string              vowel_txt[21];
        logic [15:0]        onset_jamo[19];

        function new();
            onset_txt = '{"g", "gg", "n", "d", "dd", "r", "m", "b", "bb", "s",
                          "ss", "o", "j", "jj", "ch", "k", "t", "p", "h"};
            vowel_txt = '{"a", "ae", "ya", "yae", "eo", "e", "yeo", "ye", "o", "wa",
                          "wae", "oe", "yo", "u", "wo", "we", "wi", "yu", "eu", "ui",
                          "i"};
            onset_jamo = '{16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138,
                           16'h3139, 16'h3141, 16'h3142, 16'h3143, 16'h3145,
                           16'h3146, 16'h3147, 16'h3148, 16'h3149, 16'h314A,
                           16'h314B, 16'h314C, 16'h314D, 16'h314E};
            text_len = 0;
            byte_cap = LIMIT_RESET;
            fails    = 0;
        endfunction

        // longest table entry at pos; vowels when is_vowel is set
        function int longest(input bit is_vowel, input int unsigned pos,
                             output int unsigned len);
            int    count;
            bit    ok;
            string s;
            count = is_vowel ? 21 : 19;
            for (int l = 3; l >= 1; l--)
            begin
                if (pos + l > text_len)
                    continue;
                for (int i = 0; i < count; i++)
                begin
                    s = is_vowel ? vowel_txt[i] : onset_txt[i];
                    if (s.len() != l)
                        continue;
                    ok = 1'b1;
                    for (int k = 0; k < l; k++)
                        if (text_buf[pos + k] != s[k])
                            ok = 1'b0;
                    if (ok)
                    begin
                        len = l;
                        return i;
                    end
                end
            end
            len = 0;
            return -1;
        endfunction

        function void compose_text();
            int unsigned cap;
            int unsigned pos;
            int unsigned n;
            int unsigned ilen;
            int unsigned vlen;
            int          ini;
            int          vow;
            logic [15:0] cp;
            hrc_out_t    run[$];
            cap = byte_cap;
            if (cap < LIMIT_MIN)
                cap = LIMIT_MIN;
            if (cap > LIMIT_CAP)
                cap = LIMIT_CAP;
            pos = 0;
            n   = 0;
            while (pos < text_len)
            begin
                ini = longest(1'b0, pos, ilen);
                if (ini < 0)
                begin
                    if (n + 1 >= cap)
                        break;
                    run.push_back(hrc_out_t'{text_buf[pos], 1'b1, 1'b0});
                    n++;
                    pos++;
                    continue;
                end
                vow = longest(1'b1, pos + ilen, vlen);
                if (vow >= 0)
                    cp = 16'(int'(SYL_BASE) + ini * int'(INIT_STRIDE)
                             + vow * int'(VOWEL_STRIDE));
                else
                    cp = onset_jamo[ini];
                if (n + 3 < cap)
                begin
                    run.push_back(hrc_out_t'{UTF8_LEAD3 | {4'h0, cp[15:12]}, 1'b1, 1'b0});
                    run.push_back(hrc_out_t'{UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0});
                    run.push_back(hrc_out_t'{UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0});
                    n += 3;
                end
                pos += ilen + vlen;
            end
            if (run.size() == 0)
                run.push_back(hrc_out_t'{8'h00, 1'b0, 1'b1});
            else
                run[run.size() - 1].out_last = 1'b1;
            foreach (run[i])
                pending.push_back(run[i]);
            text_len = 0;
        endfunction

        function void note_request(input hrc_in_t r);
            if (text_len < MAX_CHARS)
            begin
                text_buf[text_len] = r.in_char;
                text_len++;
            end
            if (r.in_last)
                compose_text();
        endfunction

        function void check_result(input hrc_out_t got);
            hrc_out_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: out_byte %0h out_valid %0b out_last %0b",
                       got.out_byte, got.out_valid, got.out_last);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.out_valid !== want.out_valid)
            begin
                $error("out_valid: expected %0b, actual %0b", want.out_valid, got.out_valid);
                fails++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
                fails++;
            end
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    hrc_in_t            req      = '0;
    logic               strobe;
    hrc_out_t           result;
    logic               cfg_we   = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;

    hangul_scoreboard sb;
    int               cycle_count = 0;
    int               burst_left  = 0;
    bit               calm        = 1'b0;

    hangul_romanization_composer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .strobe   (strobe),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && strobe)
            sb.check_result(result);

    task automatic send_request(input logic [7:0] c, input logic l);
        int gap;
        if (!calm)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        start <= 1'b1;
        req   <= hrc_in_t'{c, l};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(hrc_in_t'{c, l});
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i])
            send_request(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_bytes(q);
    endtask

    // only while idle: all results in and the scan closed
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.byte_cap = v;
    endtask

    initial
    begin
        logic [7:0]         text[$];
        logic [LIMIT_W-1:0] v;
        string              tok;
        int                 len;
        int                 sel;
        int                 sent_random;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit, long initial and vowel, bare initial
        send_text("jjwaech");
        text = '{8'hFF, 8'h00};
        send_bytes(text);
        // unit dropped but consumed, then copying resumes
        write_limit(7'd4);
        send_text("!ga!");
        // unmatched byte that no longer fits
        write_limit(7'd2);
        send_text("!!?");
        // no room at all gives the empty result
        write_limit(7'd1);
        send_text("ba");
        write_limit(7'd64);
        send_text("oeuigyae");

        sent_random = 0;
        while (sent_random < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 9))
                    0:       v = 7'd0;
                    1:       v = 7'd1;
                    2:       v = 7'd2;
                    3:       v = 7'd3;
                    4:       v = 7'd64;
                    5:       v = 7'd127;
                    6:       v = 7'd4;
                    default: v = 7'($urandom_range(1, 64));
                endcase
                write_limit(v);
            end
            calm = ($urandom_range(0, 4) == 0);
            sel  = $urandom_range(0, 99);
            if (sel < 5)
                len = $urandom_range(60, 72);
            else if (sel < 15)
                len = $urandom_range(17, 40);
            else
                len = $urandom_range(1, 16);
            text.delete();
            while (text.size() < len)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    tok = {sb.onset_txt[$urandom_range(0, 18)],
                           sb.vowel_txt[$urandom_range(0, 20)]};
                else if (sel < 70)
                    tok = sb.onset_txt[$urandom_range(0, 18)];
                else if (sel < 80)
                    tok = sb.vowel_txt[$urandom_range(0, 20)];
                else
                    tok = "";
                for (int k = 0; k < tok.len(); k++)
                    text.push_back(tok[k]);
                if (sel >= 80 && sel < 88)
                    text.push_back(8'($urandom_range(97, 122)));
                else if (sel >= 88)
                    text.push_back(8'($urandom_range(0, 255)));
            end
            while (text.size() > len)
                void'(text.pop_back());
            send_bytes(text);
            sent_random += len;
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ hangul_romanization_composer_top.f @@
hdl/hrc_pkg.sv
hdl/hrc_buffer.sv
hdl/hrc_calc.sv
hdl/hangul_romanization_composer_top.sv
tb/tb_hangul_romanization_composer_top.sv
